### rtl/shadow_memory_init_checker_unit_defines.svh
// Assertion macros for the shadow memory init checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef SHADOW_MEMORY_INIT_CHECKER_UNIT_DEFINES_SVH
`define SHADOW_MEMORY_INIT_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SMIC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smic: same-cycle implication violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SMIC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smic: next-cycle implication violated");

`endif

### rtl/smic_pkg.sv
// Shared constants, codes and controller/datapath structs for the shadow memory checker.
// No dependencies.
package smic_pkg;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int FUNC_W     = 3;
  localparam int POOL_SIZE  = 65536;
  localparam int SLOT_COUNT = 8192;
  localparam int SLOT_SHIFT = 3;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WIN_W      = ADDR_W + 1;
  localparam int RND_W      = SIZE_W + 1;
  localparam int OFF_W      = WIN_W - SLOT_SHIFT;
  localparam int SH_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ARM    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POISON = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 3'd4;

  // Shadow codes
  localparam logic [SH_W-1:0] SH_CLEAN  = 2'd0;
  localparam logic [SH_W-1:0] SH_UNINIT = 2'd1;
  localparam logic [SH_W-1:0] SH_POISON = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LENGTH = 2'd1;

  localparam logic [CFG_DATA_W-1:0] POOL_LENGTH_RST = CFG_DATA_W'(POOL_SIZE);

  typedef struct packed {
    logic capture;
    logic decode;
    logic clip;
    logic offset;
    logic sweep_init;
    logic write;
    logic read;
    logic advance;
    logic emit;
  } smic_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              go;
    logic              at_last;
  } smic_status_t;

endpackage

### rtl/smic_if.sv
// Valid/ready channel interfaces: operation input, result output, configuration writes.
// Depends on smic_pkg.
interface smic_in_if;
  logic                        valid;
  logic                        ready;
  logic [smic_pkg::FUNC_W-1:0] func;
  logic [smic_pkg::ADDR_W-1:0] address;
  logic [smic_pkg::SIZE_W-1:0] size;
  modport source (output valid, func, address, size, input ready);
  modport sink (input valid, func, address, size, output ready);
endinterface

interface smic_out_if;
  logic                        valid;
  logic                        ready;
  logic [smic_pkg::ADDR_W-1:0] alloc_address;
  logic                        violation;
  modport source (output valid, alloc_address, violation, input ready);
  modport sink (input valid, alloc_address, violation, output ready);
endinterface

interface smic_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [smic_pkg::CFG_IDX_W-1:0]  index;
  logic [smic_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/shadow_memory_init_checker_unit.sv
// Shadow memory init checker, top level: configuration registers, output register, assertions.
// Depends on smic_pkg, smic_if, smic_ctrl, smic_datapath, smic_ram and the defines header.
//
// Keeps a 2-bit shadow code (clean, uninitialized, poisoned) for every 8-byte slot of a
// pool of POOL_SIZE bytes, in a single-port-write, single-port-read RAM of SLOT_COUNT
// entries. After reset the block runs a clearing pass that poisons every slot, one per
// cycle; in_ch.ready stays low meanwhile, configuration writes are taken as always. Items
// are processed one at a time. Mark, poison, check and alloc pass through accept, decode,
// window clip, slot offset, dispatch and hand-off, with a walk over the slots of the
// clipped range between dispatch and hand-off (check adds a wait state to drain the
// registered RAM read). Arm skips clip, offset and dispatch and rewrites every slot.
// Zero-size, unarmed and unused codes skip the slot walk. The RAM port, one slot per cycle,
// sets the rate of every slot walk.
// A finished result sits in an output register, so the next word can be accepted while
// the previous result still waits on out_ch.ready. cfg_ch.ready is always high; write
// pool_base and pool_length only while no item is in flight. Both are read on arm.
`include "shadow_memory_init_checker_unit_defines.svh"

module shadow_memory_init_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  smic_in_if.sink     in_ch,
  smic_out_if.source  out_ch,
  smic_cfg_if.sink    cfg_ch
);

  logic [smic_pkg::CFG_DATA_W-1:0] pool_base_r;
  logic [smic_pkg::CFG_DATA_W-1:0] pool_length_r;

  logic                        out_valid_r;
  logic [smic_pkg::ADDR_W-1:0] out_alloc_address_r;
  logic                        out_violation_r;
  logic                        out_free;

  smic_pkg::smic_cmd_t    ctrl_cmd;
  smic_pkg::smic_status_t dp_status;
  logic [smic_pkg::ADDR_W-1:0] res_alloc_address;
  logic                        res_violation;

  // Configuration registers: always ready, indexes past the list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      pool_length_r <= smic_pkg::POOL_LENGTH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        smic_pkg::CFG_POOL_BASE:   pool_base_r   <= cfg_ch.data;
        smic_pkg::CFG_POOL_LENGTH: pool_length_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Output register: load a finished result when the slot is empty or being drained.
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.emit) begin
      out_alloc_address_r <= res_alloc_address;
      out_violation_r     <= res_violation;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.alloc_address = out_alloc_address_r;
  assign out_ch.violation     = out_violation_r;

  smic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .status   (dp_status),
    .in_ready (in_ch.ready),
    .cmd      (ctrl_cmd)
  );

  smic_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .pool_base         (pool_base_r),
    .pool_length       (pool_length_r),
    .in_func           (in_ch.func),
    .in_address        (in_ch.address),
    .in_size           (in_ch.size),
    .cmd               (ctrl_cmd),
    .status            (dp_status),
    .res_alloc_address (res_alloc_address),
    .res_violation     (res_violation)
  );

  // Never overwrite a result that has not been taken.
  `SMIC_ASSERT_IMP(a_emit_into_free_slot, ctrl_cmd.emit, (!out_valid_r || out_ch.ready))
  // Only check can raise a violation.
  `SMIC_ASSERT_IMP(a_viol_only_check, (ctrl_cmd.emit && (dp_status.func != smic_pkg::FUNC_CHECK)), (!res_violation))
  // Only alloc returns an address.
  `SMIC_ASSERT_IMP(a_addr_only_alloc, (ctrl_cmd.emit && (dp_status.func != smic_pkg::FUNC_ALLOC)), (res_alloc_address == '0))
  // One item at a time: stop accepting right after a word is taken.
  `SMIC_ASSERT_NXT(a_busy_after_accept, ctrl_cmd.capture, (!in_ch.ready))

endmodule

### rtl/smic_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module smic_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### rtl/smic_ctrl.sv
// Controller state machine: sequences clear, decode, clip, slot walk and result hand-off.
// Depends on smic_pkg.
module smic_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   out_free,
  input  smic_pkg::smic_status_t status,
  output logic                   in_ready,
  output smic_pkg::smic_cmd_t    cmd
);

  localparam logic [3:0] ST_INIT       = 4'd0;
  localparam logic [3:0] ST_CLEAR      = 4'd1;
  localparam logic [3:0] ST_IDLE       = 4'd2;
  localparam logic [3:0] ST_DECODE     = 4'd3;
  localparam logic [3:0] ST_CLIP       = 4'd4;
  localparam logic [3:0] ST_OFFSET     = 4'd5;
  localparam logic [3:0] ST_DISPATCH   = 4'd6;
  localparam logic [3:0] ST_FILL       = 4'd7;
  localparam logic [3:0] ST_CHECK      = 4'd8;
  localparam logic [3:0] ST_CHECK_WAIT = 4'd9;
  localparam logic [3:0] ST_DONE       = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_init = 1'b1;
        state_nxt      = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.write   = 1'b1;
        cmd.advance = 1'b1;
        if (status.at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = (status.func == smic_pkg::FUNC_ARM) ? ST_FILL : ST_CLIP;
      end
      ST_CLIP: begin
        cmd.clip  = 1'b1;
        state_nxt = ST_OFFSET;
      end
      ST_OFFSET: begin
        cmd.offset = 1'b1;
        state_nxt  = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!status.go) begin
          state_nxt = ST_DONE;
        end else if (status.func == smic_pkg::FUNC_CHECK) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.write   = 1'b1;
        cmd.advance = 1'b1;
        if (status.at_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHECK: begin
        cmd.read    = 1'b1;
        cmd.advance = 1'b1;
        if (status.at_last) begin
          state_nxt = ST_CHECK_WAIT;
        end
      end
      ST_CHECK_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/smic_datapath.sv
// Datapath: window and allocator registers, range clipping, slot cursor and shadow RAM.
// Depends on smic_pkg and smic_ram.
module smic_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [smic_pkg::CFG_DATA_W-1:0] pool_base,
  input  logic [smic_pkg::CFG_DATA_W-1:0] pool_length,
  input  logic [smic_pkg::FUNC_W-1:0]     in_func,
  input  logic [smic_pkg::ADDR_W-1:0]     in_address,
  input  logic [smic_pkg::SIZE_W-1:0]     in_size,
  input  smic_pkg::smic_cmd_t             cmd,
  output smic_pkg::smic_status_t          status,
  output logic [smic_pkg::ADDR_W-1:0]     res_alloc_address,
  output logic                            res_violation
);

  localparam int ADDR_W = smic_pkg::ADDR_W;
  localparam int WIN_W  = smic_pkg::WIN_W;
  localparam int RND_W  = smic_pkg::RND_W;
  localparam int OFF_W  = smic_pkg::OFF_W;
  localparam int SLOT_W = smic_pkg::SLOT_W;

  localparam logic [SLOT_W-1:0] SLOT_MAX     = SLOT_W'(smic_pkg::SLOT_COUNT - 1);
  localparam logic [OFF_W-1:0]  SLOT_CNT_OFF = OFF_W'(smic_pkg::SLOT_COUNT);
  localparam logic [OFF_W-1:0]  SLOT_MAX_OFF = OFF_W'(smic_pkg::SLOT_COUNT - 1);
  localparam logic [ADDR_W-1:0] POOL_CAP     = ADDR_W'(smic_pkg::POOL_SIZE);
  localparam logic [RND_W-1:0]  RND_MASK     = RND_W'((1 << smic_pkg::SLOT_SHIFT) - 1);

  logic [smic_pkg::FUNC_W-1:0] func_r;
  logic [ADDR_W-1:0]           addr_r;
  logic [smic_pkg::SIZE_W-1:0] size_r;
  logic                        armed_r;
  logic [ADDR_W-1:0]           wb_r;
  logic [WIN_W-1:0]            we_r;
  logic [WIN_W-1:0]            nf_r;
  logic [WIN_W-1:0]            rng_lo_r;
  logic [WIN_W-1:0]            rng_hi_r;
  logic [smic_pkg::SH_W-1:0]   code_r;
  logic                        go_r;
  logic [SLOT_W-1:0]           cur_r;
  logic [SLOT_W-1:0]           last_r;
  logic                        rd_pend_r;
  logic [ADDR_W-1:0]           res_addr_r;
  logic                        viol_r;
  logic [smic_pkg::SH_W-1:0]   rd_data;

  logic [RND_W-1:0]  rounded;
  logic [WIN_W:0]    nf_sum;
  logic              alloc_ok;
  logic [WIN_W-1:0]  rng_end;
  logic              range_live;
  logic              start_in_win;
  logic [ADDR_W-1:0] len_cap;
  logic [WIN_W-1:0]  lo_c;
  logic [WIN_W-1:0]  hi_c;
  logic [WIN_W-1:0]  off_lo;
  logic [WIN_W-1:0]  off_hi;
  logic [OFF_W-1:0]  first_full;
  logic [OFF_W-1:0]  last_full;

  always_comb begin
    rounded      = (RND_W'(size_r) + RND_MASK) & ~RND_MASK;
    nf_sum       = {1'b0, nf_r} + (WIN_W + 1)'(rounded);
    alloc_ok     = armed_r && !nf_r[WIN_W-1] && (nf_sum <= {1'b0, we_r});
    rng_end      = WIN_W'(addr_r) + WIN_W'(size_r);
    range_live   = armed_r && (size_r != '0);
    start_in_win = (addr_r >= wb_r) && (WIN_W'(addr_r) < we_r);
    len_cap      = (pool_length < POOL_CAP) ? pool_length : POOL_CAP;
    lo_c         = (rng_lo_r < WIN_W'(wb_r)) ? WIN_W'(wb_r) : rng_lo_r;
    hi_c         = (rng_hi_r > we_r) ? we_r : rng_hi_r;
    off_lo       = rng_lo_r - WIN_W'(wb_r);
    off_hi       = rng_hi_r - WIN_W'(wb_r) - WIN_W'(1);
    first_full   = off_lo[WIN_W-1:smic_pkg::SLOT_SHIFT];
    last_full    = off_hi[WIN_W-1:smic_pkg::SLOT_SHIFT];
  end

  // Window and allocator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      wb_r      <= '0;
      we_r      <= '0;
      nf_r      <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.read;
      if (cmd.decode && (func_r == smic_pkg::FUNC_ARM)) begin
        armed_r <= 1'b1;
        wb_r    <= pool_base;
        we_r    <= WIN_W'(pool_base) + WIN_W'(len_cap);
        nf_r    <= WIN_W'(pool_base);
      end else if (cmd.decode && (func_r == smic_pkg::FUNC_ALLOC) && alloc_ok) begin
        nf_r <= nf_sum[WIN_W-1:0];
      end
    end
  end

  // Item, range and cursor
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_func;
      addr_r     <= in_address;
      size_r     <= in_size;
      res_addr_r <= '0;
      viol_r     <= 1'b0;
    end else if (rd_pend_r && (rd_data != smic_pkg::SH_CLEAN)) begin
      viol_r <= 1'b1;
    end

    if (cmd.sweep_init) begin
      cur_r  <= '0;
      last_r <= SLOT_MAX;
      code_r <= smic_pkg::SH_POISON;
    end else if (cmd.decode) begin
      case (func_r)
        smic_pkg::FUNC_ARM: begin
          cur_r  <= '0;
          last_r <= SLOT_MAX;
          code_r <= smic_pkg::SH_POISON;
        end
        smic_pkg::FUNC_ALLOC: begin
          rng_lo_r <= nf_r;
          rng_hi_r <= nf_sum[WIN_W-1:0];
          code_r   <= smic_pkg::SH_UNINIT;
          go_r     <= alloc_ok && (rounded != '0);
          if (alloc_ok) begin
            res_addr_r <= nf_r[ADDR_W-1:0];
          end
        end
        smic_pkg::FUNC_MARK: begin
          rng_lo_r <= WIN_W'(addr_r);
          rng_hi_r <= rng_end;
          code_r   <= smic_pkg::SH_CLEAN;
          go_r     <= range_live;
        end
        smic_pkg::FUNC_POISON: begin
          rng_lo_r <= WIN_W'(addr_r);
          rng_hi_r <= rng_end;
          code_r   <= smic_pkg::SH_POISON;
          go_r     <= range_live;
        end
        smic_pkg::FUNC_CHECK: begin
          rng_lo_r <= WIN_W'(addr_r);
          rng_hi_r <= rng_end;
          go_r     <= range_live && start_in_win;
        end
        default: begin
          go_r <= 1'b0;
        end
      endcase
    end else if (cmd.clip) begin
      rng_lo_r <= lo_c;
      rng_hi_r <= hi_c;
      go_r     <= go_r && (lo_c < hi_c);
    end else if (cmd.offset) begin
      cur_r  <= first_full[SLOT_W-1:0];
      last_r <= (last_full > SLOT_MAX_OFF) ? SLOT_MAX : last_full[SLOT_W-1:0];
      go_r   <= go_r && (first_full < SLOT_CNT_OFF);
    end else if (cmd.advance) begin
      cur_r <= cur_r + SLOT_W'(1);
    end
  end

  smic_ram #(
    .WIDTH (smic_pkg::SH_W),
    .DEPTH (smic_pkg::SLOT_COUNT)
  ) u_shadow_ram (
    .clk     (clk),
    .we      (cmd.write),
    .waddr   (cur_r),
    .wdata   (code_r),
    .re      (cmd.read),
    .raddr   (cur_r),
    .rdata_r (rd_data)
  );

  assign status.func       = func_r;
  assign status.go         = go_r;
  assign status.at_last    = (cur_r == last_r);
  assign res_alloc_address = res_addr_r;
  assign res_violation     = viol_r;

endmodule
